// File: sv/spg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spg_pkg;

  localparam int unsigned MaxPatternLen = 8;
  localparam int unsigned PatternW      = 64;
  localparam int unsigned CfgIdxW       = 8;
  localparam int unsigned CfgDataW      = 64;
  localparam logic [7:0]  InvertMask    = 8'hff;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_BYTES   = 8'd0,
    REG_PATTERN_LENGTH  = 8'd1,
    REG_INVERT_PATTERN  = 8'd2,
    REG_SYNC_COUNT      = 8'd3,
    REG_PASS_UNTIL_SYNC = 8'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SRCH,
    ST_FILL,
    ST_DRAIN
  } spg_state_e;

  // Byte k of the pattern word, byte 0 in the low bits.
  function automatic logic [7:0] pat_byte(logic [PatternW-1:0] pattern, logic [2:0] idx);
    logic [PatternW-1:0] sh;
    sh = pattern >> {idx, 3'b000};
    return sh[7:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/spg_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface spg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

// File: sv/spg_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface spg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       gate_switched;

  modport source (output valid, output out_byte, output last_of_run, output gate_switched,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input gate_switched,
                  output ready);
endinterface
`default_nettype wire

// File: sv/spg_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface spg_cfg_if;
  import spg_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: sv/sync_pattern_gate_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: after the input transfer, one compare per fallback step plus one, shift search
//   steps and up to 8 regenerated bytes; the results then transfer one per cycle while
//   the output is ready.
// Throughput: one byte at a time; a new byte is taken only in idle, after the last byte's
//   work and results, through the single byte comparator and the shift-match unit.
// Reset: rst_ni is asynchronous, active low; control and configuration registers take their
//   reset values (length 1, sync count 1, gate not switched, no partial match, empty buffer).
module sync_pattern_gate_unit #(
  parameter int unsigned MaxPatLen = spg_pkg::MaxPatternLen
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spg_in_if.sink     in_ch,
  spg_out_if.source  out_ch,
  spg_cfg_if.sink    cfg_ch
);
  import spg_pkg::*;

  localparam int unsigned CntW = $clog2(MaxPatLen + 1);
  localparam int unsigned IdxW = (MaxPatLen > 1) ? $clog2(MaxPatLen) : 1;

  // Configuration registers
  logic [PatternW-1:0] pattern_q;
  logic [3:0]          len_q;
  logic                invert_q;
  logic                pass_q;

  // Sequencer and datapath state
  spg_state_e          state_q, state_d;
  logic [7:0]          byte_q, byte_d;
  logic [3:0]          depth_q, depth_d;
  logic [15:0]         syncs_q, syncs_d;
  logic                sw_q, sw_d;
  logic [2:0]          shift_q, shift_d;
  logic [2:0]          fill_idx_q, fill_idx_d;
  logic [3:0]          fill_cnt_q, fill_cnt_d;
  logic                fill_ret_q, fill_ret_d;
  logic [CntW-1:0]     wr_cnt_q, wr_cnt_d;
  logic [IdxW-1:0]     rd_q, rd_d;
  logic [7:0]          buf_q [MaxPatLen];

  logic                cfg_fire, in_fire, out_fire;
  logic [3:0]          eff_len;
  logic [7:0]          cmp_byte;
  logic                hit;
  logic [3:0]          depth_inc;
  logic [15:0]         syncs_dec;
  logic                same;
  logic                found;
  logic [2:0]          shift_amt;
  logic [7:0]          fill_byte;
  logic                last_rd;
  logic                wr_en;
  logic [7:0]          wr_data;

  // Hold off input transfers while a configuration transfer is offered.
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // Length zero acts as one; clamp oversize lengths.
  always_comb begin
    if (len_q == 4'd0) begin
      eff_len = 4'd1;
    end else if (len_q > 4'(MaxPatLen)) begin
      eff_len = 4'(MaxPatLen);
    end else begin
      eff_len = len_q;
    end
  end

  // Shared byte comparator: current pattern byte against the held input byte.
  assign cmp_byte  = pat_byte(pattern_q, depth_q[2:0]) ^ (invert_q ? InvertMask : 8'h00);
  assign hit       = (byte_q == cmp_byte);
  assign depth_inc = depth_q + 4'd1;
  assign syncs_dec = (syncs_q != 16'd0) ? (syncs_q - 16'd1) : syncs_q;
  assign fill_byte = pat_byte(pattern_q, fill_idx_q) ^ (invert_q ? InvertMask : 8'h00);
  assign last_rd   = ((CntW'(rd_q) + CntW'(1)) == wr_cnt_q);

  // Shift search: smallest shift whose overlap agrees, or the whole held prefix.
  spg_shift_match u_shift_match (
    .pattern_i (pattern_q),
    .shift_i   (shift_q),
    .depth_i   (depth_q),
    .same_o    (same)
  );

  assign found     = same || ((4'(shift_q) + 4'd1) == depth_q);
  assign shift_amt = same ? shift_q : (shift_q + 3'd1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (sw_q) begin
            state_d = pass_q ? ST_IDLE : ST_DRAIN;
          end else begin
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (hit) begin
          if ((depth_inc == eff_len) &&
              ((syncs_dec == 16'd0) ? !pass_q : pass_q)) begin
            state_d = ST_FILL;
          end else begin
            state_d = (wr_cnt_q != '0) ? ST_DRAIN : ST_IDLE;
          end
        end else if (depth_q == 4'd0) begin
          state_d = (pass_q || (wr_cnt_q != '0)) ? ST_DRAIN : ST_IDLE;
        end else begin
          state_d = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (found) begin
          state_d = pass_q ? ST_FILL : ST_CMP;
        end
      end
      ST_FILL: begin
        if ((4'(fill_idx_q) + 4'd1) == fill_cnt_q) begin
          state_d = fill_ret_q ? ST_CMP : ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_fire && last_rd) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake and result outputs
  always_comb begin
    in_ch.ready          = (state_q == ST_IDLE) && !cfg_ch.valid;
    cfg_ch.ready         = (state_q == ST_IDLE);
    out_ch.valid         = (state_q == ST_DRAIN);
    out_ch.out_byte      = buf_q[rd_q];
    out_ch.last_of_run   = last_rd;
    out_ch.gate_switched = sw_q;
  end

  // Datapath
  always_comb begin
    byte_d     = byte_q;
    depth_d    = depth_q;
    syncs_d    = syncs_q;
    sw_d       = sw_q;
    shift_d    = shift_q;
    fill_idx_d = fill_idx_q;
    fill_cnt_d = fill_cnt_q;
    fill_ret_d = fill_ret_q;
    wr_cnt_d   = wr_cnt_q;
    rd_d       = rd_q;
    wr_en      = 1'b0;
    wr_data    = byte_q;

    if (cfg_fire) begin
      // Any known register write drops the partial match.
      unique case (cfg_ch.index)
        REG_PATTERN_BYTES, REG_PATTERN_LENGTH, REG_INVERT_PATTERN,
        REG_PASS_UNTIL_SYNC: begin
          depth_d = 4'd0;
        end
        REG_SYNC_COUNT: begin
          depth_d = 4'd0;
          syncs_d = cfg_ch.data[15:0];
          sw_d    = (cfg_ch.data[15:0] == 16'd0);
        end
        default: ;
      endcase
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            byte_d   = in_ch.data_byte;
            wr_cnt_d = '0;
            rd_d     = '0;
            if (sw_q) begin
              // Gate already open: drop mode forwards the byte as is.
              wr_en   = !pass_q;
              wr_data = in_ch.data_byte;
              wr_cnt_d = pass_q ? CntW'(0) : CntW'(1);
            end else if (depth_q >= eff_len) begin
              depth_d = 4'd0;
            end
          end
        end
        ST_CMP: begin
          if (hit) begin
            if (depth_inc == eff_len) begin
              // Full sync found: count it and regenerate the pattern bytes if they go out.
              syncs_d    = syncs_dec;
              depth_d    = 4'd0;
              fill_idx_d = 3'd0;
              fill_cnt_d = eff_len;
              fill_ret_d = 1'b0;
              if (syncs_dec == 16'd0) begin
                sw_d = 1'b1;
              end
            end else begin
              depth_d = depth_inc;
            end
          end else if (depth_q == 4'd0) begin
            if (pass_q) begin
              wr_en    = 1'b1;
              wr_data  = byte_q;
              wr_cnt_d = wr_cnt_q + CntW'(1);
            end
          end else begin
            shift_d = 3'd1;
          end
        end
        ST_SRCH: begin
          if (found) begin
            // Fall back; the shifted-out bytes leave only in pass mode.
            depth_d    = depth_q - 4'(shift_amt);
            fill_idx_d = 3'd0;
            fill_cnt_d = 4'(shift_amt);
            fill_ret_d = 1'b1;
          end else begin
            shift_d = shift_q + 3'd1;
          end
        end
        ST_FILL: begin
          wr_en      = 1'b1;
          wr_data    = fill_byte;
          wr_cnt_d   = wr_cnt_q + CntW'(1);
          fill_idx_d = fill_idx_q + 3'd1;
        end
        ST_DRAIN: begin
          if (out_fire) begin
            rd_d = last_rd ? IdxW'(0) : (rd_q + IdxW'(1));
            // Empty the buffer so the next run writes from slot zero.
            if (last_rd) begin
              wr_cnt_d = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q  <= '0;
      len_q      <= 4'd1;
      invert_q   <= 1'b0;
      pass_q     <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_ch.index)
        REG_PATTERN_BYTES:   pattern_q  <= cfg_ch.data;
        REG_PATTERN_LENGTH:  len_q      <= cfg_ch.data[3:0];
        REG_INVERT_PATTERN:  invert_q   <= cfg_ch.data[0];
        REG_PASS_UNTIL_SYNC: pass_q     <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      depth_q    <= 4'd0;
      syncs_q    <= 16'd1;
      sw_q       <= 1'b0;
      shift_q    <= 3'd1;
      fill_idx_q <= 3'd0;
      fill_cnt_q <= 4'd0;
      fill_ret_q <= 1'b0;
      wr_cnt_q   <= '0;
      rd_q       <= '0;
    end else begin
      state_q    <= state_d;
      depth_q    <= depth_d;
      syncs_q    <= syncs_d;
      sw_q       <= sw_d;
      shift_q    <= shift_d;
      fill_idx_q <= fill_idx_d;
      fill_cnt_q <= fill_cnt_d;
      fill_ret_q <= fill_ret_d;
      wr_cnt_q   <= wr_cnt_d;
      rd_q       <= rd_d;
    end
  end

  // Payload: held byte and result buffer
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (wr_en) begin
      buf_q[wr_cnt_q[IdxW-1:0]] <= wr_data;
    end
  end

  // A drain never starts with an empty buffer.
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (wr_cnt_q != '0))
    else $error("drain with empty result buffer");

  // The buffer never holds more bytes than the longest pattern.
  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_cnt_q <= CntW'(MaxPatLen))
    else $error("result buffer overflow");

  // Every compare uses a depth inside the effective pattern.
  a_depth_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (depth_q < eff_len))
    else $error("match depth beyond pattern length");

  // The final result of a run returns the sequencer to idle.
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_ch.last_of_run) |=> (state_q == ST_IDLE))
    else $error("run did not end after last result");

  // A byte taken before the gate switches always goes through a compare.
  a_accept_to_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !sw_q) |=> (state_q == ST_CMP))
    else $error("accepted byte skipped the compare");

endmodule
`default_nettype wire

// File: sv/spg_shift_match.sv
`timescale 1ns / 1ps
`default_nettype none
module spg_shift_match (
  input  wire logic [spg_pkg::PatternW-1:0] pattern_i,
  input  wire logic [2:0]                   shift_i,
  input  wire logic [3:0]                   depth_i,
  output logic                              same_o
);
  import spg_pkg::*;

  logic [PatternW-1:0] shifted;
  logic [7:0]          hit;

  // Compare pattern[k] against pattern[k + shift] for every k still inside the held prefix.
  always_comb begin
    shifted = pattern_i >> {shift_i, 3'b000};
    for (int k = 0; k < 8; k++) begin
      if ((4'(k) + {1'b0, shift_i}) < depth_i) begin
        hit[k] = (pattern_i[8*k +: 8] == shifted[8*k +: 8]);
      end else begin
        hit[k] = 1'b1;
      end
    end
  end

  assign same_o = &hit;

endmodule
`default_nettype wire
